// ===== rtl/core/bfa_pkg.sv =====
// Shared types and field widths for the best-fit partition allocator.
package bfa_pkg;

	localparam int TYPE_W   = 2;
	localparam int PIDX_W   = 4;
	localparam int AMT_W    = 16;
	localparam int OWNER_W  = 6;
	localparam int STAT_W   = 2;
	localparam int CHOSEN_W = 4;
	localparam int LEFT_W   = 16;
	localparam int FRAG_W   = 20;
	localparam int EXT_W    = 22;

	typedef enum logic [TYPE_W-1:0] {
		REQ_LOAD   = 2'd0,
		REQ_ALLOC  = 2'd1,
		REQ_REPORT = 2'd2
	} req_t;

	typedef enum logic [STAT_W-1:0] {
		ST_LOADED = 2'd0,
		ST_PLACED = 2'd1,
		ST_REJECT = 2'd2,
		ST_REPORT = 2'd3
	} status_t;

endpackage

// ===== rtl/core/bfa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bfa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/bfa_unit.sv =====
// Shared add/subtract and magnitude compare unit used by every scan step.
module bfa_unit #(
	parameter int W = 22
) (
	input  logic         sub,
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	input  logic [W-1:0] c,
	input  logic [W-1:0] d,
	output logic [W:0]   res,
	output logic         lt
);

	// top bit of res is the carry on add, the borrow on subtract
	assign res = sub ? ({1'b0, a} - {1'b0, b}) : ({1'b0, a} + {1'b0, b});
	assign lt  = (c < d);

endmodule

// ===== rtl/core/best_fit_block_allocator.sv =====
// Best-fit fixed-partition allocator: partition table, rejected-size list and scan sequencer.
//
// One word in, one word out, handled one at a time. A load word goes from idle to the
// finish state and then to the result register. An allocate word scans the partition
// table once, one entry a cycle through the table RAM's single read port, then claims the
// chosen entry or keeps the rejected size while there is room. A report word scans the
// table and then the list of rejected sizes, one entry a cycle each through the shared
// adder; the list scan is skipped when no sizes are kept. Requests of type 3 are dropped
// without a result. The table comes out of reset empty through per-entry valid flags, so
// there is no clearing pass; the rejected list needs none as only written entries are read.
// The result register lets a new word in while the previous result waits to be taken;
// the sequencer stalls only when a result is ready and the register is still full.
module best_fit_block_allocator
	import bfa_pkg::*;
#(
	parameter int PARTITIONS = 16,
	parameter int PROCESSES  = 64,
	parameter int SIZE_BITS  = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [TYPE_W-1:0]   req_type,
	input  logic [PIDX_W-1:0]   part_index,
	input  logic [AMT_W-1:0]    amount,
	input  logic [OWNER_W-1:0]  proc_id,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [STAT_W-1:0]   status,
	output logic [CHOSEN_W-1:0] chosen_part,
	output logic [LEFT_W-1:0]   leftover,
	output logic [FRAG_W-1:0]   internal_frag,
	output logic [FRAG_W-1:0]   free_total,
	output logic [EXT_W-1:0]    external_frag
);

	localparam int PIW     = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
	localparam int RW      = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
	localparam int CW      = $clog2(PROCESSES + 1);
	localparam int IW      = (PIW > RW) ? PIW : RW;
	localparam int SW      = SIZE_BITS;
	localparam int SUM_W   = SW + PIW;
	localparam int UW      = (SUM_W > EXT_W) ? SUM_W : EXT_W;
	localparam int ENT_W   = 1 + OWNER_W + 2 * SW;
	localparam int REM_LO  = SW;
	localparam int OWN_LO  = 2 * SW;
	localparam int OWNED_B = ENT_W - 1;

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_ASCAN  = 6'b000010,
		S_AWRITE = 6'b000100,
		S_PSCAN  = 6'b001000,
		S_RSCAN  = 6'b010000,
		S_FINISH = 6'b100000
	} state_t;

	state_t                  state_q;
	logic [IW-1:0]           issue_q;
	logic                    issue_done_q;
	logic                    vld_s1;
	logic [IW-1:0]           idx_s1;
	logic [PARTITIONS-1:0]   part_vld_q;
	logic [CW-1:0]           rej_cnt_q;
	logic [SW-1:0]           amt_q;
	logic [OWNER_W-1:0]      pid_q;
	logic                    found_q;
	logic [PIW-1:0]          best_idx_q;
	logic [SW-1:0]           best_rem_q;
	logic [SW-1:0]           best_size_q;
	status_t                 stat_q;
	logic [UW-1:0]           intf_q;
	logic [UW-1:0]           freet_q;
	logic [UW-1:0]           extf_q;
	logic                    out_valid_q;
	logic [STAT_W-1:0]       status_q;
	logic [CHOSEN_W-1:0]     chosen_q;
	logic [LEFT_W-1:0]       leftover_q;
	logic [FRAG_W-1:0]       intf_out_q;
	logic [FRAG_W-1:0]       freet_out_q;
	logic [EXT_W-1:0]        extf_out_q;

	logic                    in_acc;
	logic                    p_we;
	logic [PIW-1:0]          p_waddr;
	logic [ENT_W-1:0]        p_wdata;
	logic [ENT_W-1:0]        p_rdata;
	logic                    r_we;
	logic [SW-1:0]           r_rdata;
	logic                    e_ok;
	logic                    e_owned;
	logic [SW-1:0]           e_size;
	logic [SW-1:0]           e_rem;
	logic [IW-1:0]           scan_last;
	logic                    scanning;
	logic                    data_last;
	logic                    fits;
	logic                    better;
	logic                    load_ok;
	logic                    res_go;

	logic                    u_sub;
	logic [UW-1:0]           u_a;
	logic [UW-1:0]           u_b;
	logic [UW-1:0]           u_c;
	logic [UW-1:0]           u_d;
	logic [UW:0]             u_res;
	logic                    u_lt;

	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign load_ok  = (int'(part_index) < PARTITIONS);
	assign res_go   = (state_q == S_FINISH) && (!out_valid_q || out_ready);

	// table entry as read back; an entry never loaded reads as all zero
	assign e_ok    = part_vld_q[idx_s1[PIW-1:0]];
	assign e_owned = e_ok && p_rdata[OWNED_B];
	assign e_size  = e_ok ? p_rdata[SW-1:0] : '0;
	assign e_rem   = e_ok ? p_rdata[REM_LO +: SW] : '0;

	assign scan_last = (state_q == S_RSCAN) ? IW'(rej_cnt_q - CW'(1)) : IW'(PARTITIONS - 1);
	assign scanning  = (state_q == S_ASCAN || state_q == S_PSCAN || state_q == S_RSCAN);
	assign data_last = vld_s1 && (idx_s1 == scan_last);

	// borrow clear means the process fits; equal remaining spaces keep the earlier index
	assign fits   = !e_owned && !u_res[UW];
	assign better = !found_q || u_lt;

	// partition table write: load from the input, or claim of the chosen entry
	always_comb begin
		p_we    = 1'b0;
		p_waddr = best_idx_q;
		p_wdata = {1'b1, pid_q, u_res[SW-1:0], best_size_q};
		if (state_q == S_IDLE) begin
			p_we    = in_acc && (req_type == REQ_LOAD) && load_ok;
			p_waddr = PIW'(part_index);
			p_wdata = {1'b0, {OWNER_W{1'b0}}, SW'(amount), SW'(amount)};
		end else if (state_q == S_AWRITE) begin
			p_we = found_q;
		end
	end

	assign r_we = (state_q == S_AWRITE) && !found_q && (rej_cnt_q < CW'(PROCESSES));

	// operand selection for the shared unit
	always_comb begin
		u_sub = 1'b0;
		u_a   = '0;
		u_b   = '0;
		u_c   = '0;
		u_d   = '0;
		case (state_q)
			S_ASCAN: begin
				u_sub = 1'b1;
				u_a   = UW'(e_rem);
				u_b   = UW'(amt_q);
				u_c   = UW'(e_rem);
				u_d   = UW'(best_rem_q);
			end
			S_AWRITE: begin
				u_sub = 1'b1;
				u_a   = UW'(best_rem_q);
				u_b   = UW'(amt_q);
			end
			S_PSCAN: begin
				u_a = e_owned ? intf_q : freet_q;
				u_b = e_owned ? UW'(e_rem) : UW'(e_size);
			end
			S_RSCAN: begin
				u_a = extf_q;
				u_b = UW'(r_rdata);
				u_c = freet_q;
				u_d = UW'(r_rdata);
			end
			default: begin
				u_sub = 1'b0;
			end
		endcase
	end

	bfa_ram #(
		.WIDTH (ENT_W),
		.DEPTH (PARTITIONS)
	) u_part_ram (
		.clk   (clk),
		.we    (p_we),
		.waddr (p_waddr),
		.wdata (p_wdata),
		.raddr (issue_q[PIW-1:0]),
		.rdata (p_rdata)
	);

	bfa_ram #(
		.WIDTH (SW),
		.DEPTH (PROCESSES)
	) u_rej_ram (
		.clk   (clk),
		.we    (r_we),
		.waddr (rej_cnt_q[RW-1:0]),
		.wdata (amt_q),
		.raddr (issue_q[RW-1:0]),
		.rdata (r_rdata)
	);

	bfa_unit #(
		.W (UW)
	) u_unit (
		.sub (u_sub),
		.a   (u_a),
		.b   (u_b),
		.c   (u_c),
		.d   (u_d),
		.res (u_res),
		.lt  (u_lt)
	);

	// sequencer and scan address counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			issue_q      <= '0;
			issue_done_q <= 1'b0;
			vld_s1       <= 1'b0;
			part_vld_q   <= '0;
			rej_cnt_q    <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			// read one entry a cycle until the last address has gone out
			vld_s1 <= scanning && !issue_done_q;
			if (scanning && !issue_done_q) begin
				if (issue_q == scan_last) begin
					issue_done_q <= 1'b1;
				end else begin
					issue_q <= issue_q + IW'(1);
				end
			end

			// result register: filled when the sequencer finishes, emptied when taken
			if (res_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					issue_q      <= '0;
					issue_done_q <= 1'b0;
					if (in_acc) begin
						case (req_type)
							REQ_LOAD: begin
								if (load_ok) begin
									part_vld_q[PIW'(part_index)] <= 1'b1;
								end
								state_q <= S_FINISH;
							end
							REQ_ALLOC:  state_q <= S_ASCAN;
							REQ_REPORT: state_q <= S_PSCAN;
							default:    state_q <= S_IDLE;
						endcase
					end
				end
				S_ASCAN: begin
					if (data_last) begin
						state_q <= S_AWRITE;
					end
				end
				S_AWRITE: begin
					if (found_q) begin
						part_vld_q[best_idx_q] <= 1'b1;
					end
					if (r_we) begin
						rej_cnt_q <= rej_cnt_q + CW'(1);
					end
					state_q <= S_FINISH;
				end
				S_PSCAN: begin
					if (data_last) begin
						issue_q      <= '0;
						issue_done_q <= 1'b0;
						state_q      <= (rej_cnt_q == '0) ? S_FINISH : S_RSCAN;
					end
				end
				S_RSCAN: begin
					if (data_last) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (res_go) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		idx_s1 <= issue_q;
		case (state_q)
			S_IDLE: begin
				amt_q   <= SW'(amount);
				pid_q   <= proc_id;
				found_q <= 1'b0;
				intf_q  <= '0;
				freet_q <= '0;
				extf_q  <= '0;
				stat_q  <= (req_type == REQ_REPORT) ? ST_REPORT : ST_LOADED;
			end
			S_ASCAN: begin
				if (vld_s1 && fits && better) begin
					found_q     <= 1'b1;
					best_idx_q  <= idx_s1[PIW-1:0];
					best_rem_q  <= e_rem;
					best_size_q <= e_size;
				end
			end
			S_AWRITE: begin
				best_rem_q <= u_res[SW-1:0];
				stat_q     <= found_q ? ST_PLACED : ST_REJECT;
			end
			S_PSCAN: begin
				if (vld_s1) begin
					if (e_owned) begin
						intf_q <= u_res[UW-1:0];
					end else begin
						freet_q <= u_res[UW-1:0];
					end
				end
			end
			S_RSCAN: begin
				// sizes above the free total do not count
				if (vld_s1 && !u_lt) begin
					extf_q <= u_res[UW-1:0];
				end
			end
			default: begin
				found_q <= found_q;
			end
		endcase

		if (res_go) begin
			status_q    <= stat_q;
			chosen_q    <= (stat_q == ST_PLACED) ? CHOSEN_W'(best_idx_q) : '0;
			leftover_q  <= (stat_q == ST_PLACED) ? LEFT_W'(best_rem_q) : '0;
			intf_out_q  <= (stat_q == ST_REPORT) ? FRAG_W'(intf_q) : '0;
			freet_out_q <= (stat_q == ST_REPORT) ? FRAG_W'(freet_q) : '0;
			extf_out_q  <= (stat_q == ST_REPORT) ? EXT_W'(extf_q) : '0;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign chosen_part   = chosen_q;
	assign leftover      = leftover_q;
	assign internal_frag = intf_out_q;
	assign free_total    = freet_out_q;
	assign external_frag = extf_out_q;

`ifndef NO_ASSERTIONS
	// read data only returns while a scan runs
	a_scan_data: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (state_q == S_ASCAN || state_q == S_PSCAN || state_q == S_RSCAN))
		else $error("scan data outside a scan");

	// a rejected size is kept while there is room
	a_rej_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_AWRITE && !found_q && rej_cnt_q < CW'(PROCESSES))
		|=> (rej_cnt_q == $past(rej_cnt_q) + CW'(1)))
		else $error("rejected size not kept");

	// a waiting result is never overwritten
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FINISH && out_valid_q && !out_ready)
		|=> (state_q == S_FINISH && out_valid_q))
		else $error("result register overrun");

	// an allocate word holds off the next word
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && req_type == REQ_ALLOC) |=> !in_ready)
		else $error("accepted a word while scanning");
`endif

endmodule
